### design/nlsd_pkg.sv
// shared types and constants of the nibble log sentence decoder
// no dependencies; used by nlsd_front, nlsd_exec, nlsd_outq and the top level
package nlsd_pkg;

    localparam int REG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 6;

    localparam logic [REG_INDEX_W-1:0] REG_MASK_RMC  = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_MASK_GGA  = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_MASK_GSA  = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_MASK_VTG  = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_COUNT_RMC = 3'd4;
    localparam logic [REG_INDEX_W-1:0] REG_COUNT_GGA = 3'd5;
    localparam logic [REG_INDEX_W-1:0] REG_COUNT_GSA = 3'd6;
    localparam logic [REG_INDEX_W-1:0] REG_COUNT_VTG = 3'd7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [3:0] NIB_END    = 4'hF;
    localparam logic [3:0] NIB_MAX_TYPE = 4'd3;
    localparam logic [3:0] NIB_DIGITS = 4'd10;
    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_LOW  = 7'h20;
    localparam logic [6:0] ASCII_COMMA = 7'h2C;
    localparam logic [6:0] CHAR_SKIP  = 7'h7F;

    typedef struct packed {
        logic [3:0] nib;
        logic       start;
    } t_nib_op;

    typedef struct packed {
        logic [6:0] out_char;
        logic [1:0] sentence_type;
        logic       last_char;
        logic [1:0] status;
    } t_item;

endpackage

### design/nlsd_front.sv
// front end: two-entry record byte queue that hands out one nibble operation at a time
// depends on nlsd_pkg
module nlsd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_rec_byte,
    input  logic             i_rec_start,
    output logic             o_nib_valid,
    output nlsd_pkg::t_nib_op o_nib,
    input  logic             i_nib_pop
);

    typedef struct packed {
        logic [7:0] rec_byte;
        logic       rec_start;
    } t_rec;

    t_rec       r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_half;

    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       n_half;
    logic       do_push;
    logic       do_pop_byte;
    t_rec       head;

    assign full        = (r_count == 2'd2);
    assign do_push     = push && !full;
    assign head        = r_data[r_rd_ptr];
    assign o_nib_valid = (r_count != 2'd0);
    assign o_nib.nib   = r_half ? head.rec_byte[7:4] : head.rec_byte[3:0];
    assign o_nib.start = !r_half && head.rec_start;
    assign do_pop_byte = i_nib_pop && o_nib_valid && r_half;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_half   = r_half;
        if (do_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_nib_pop && o_nib_valid) begin
            n_half = !r_half;
        end
        if (do_pop_byte) begin
            n_rd_ptr = !r_rd_ptr;
        end
        case ({do_push, do_pop_byte})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_half   <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_half   <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= '{rec_byte: i_rec_byte, rec_start: i_rec_start};
        end
    end

endmodule

### design/nlsd_exec.sv
// back end: sentence state, field models and character generation, at most one result per cycle
// depends on nlsd_pkg
module nlsd_exec #(
    parameter int SENTENCE_CAP = 256,
    parameter int MAX_FIELDS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nlsd_pkg::REG_INDEX_W-1:0]    i_cfg_index,
    input  logic [nlsd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_nib_valid,
    input  nlsd_pkg::t_nib_op                   i_nib,
    output logic                                o_nib_pop,
    input  logic                                i_out_full,
    output logic                                o_item_push,
    output nlsd_pkg::t_item                     o_item
);

    localparam int CW = (SENTENCE_CAP > 2) ? $clog2(SENTENCE_CAP) : 1;
    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam logic [CW-1:0] CC_LAST = CW'(SENTENCE_CAP - 1);
    localparam logic [7:0]    MAXF    = 8'(MAX_FIELDS);

    logic [nlsd_pkg::CFG_DATA_W-1:0] r_mask  [4];
    logic [nlsd_pkg::COUNT_W-1:0]    r_count [4];

    logic          r_active, n_active;
    logic          r_type_pending, n_type_pending;
    logic [1:0]    r_type, n_type;
    logic [FW-1:0] r_field, n_field;
    logic [3:0]    r_lh, n_lh;
    logic          r_hv, n_hv;
    logic [CW-1:0] r_cc, n_cc;
    logic          r_comma_pend, n_comma_pend;

    logic       out_ready;
    logic [1:0] type_sel;
    logic [7:0] eff;
    logic [7:0] field8;
    logic       quartet;
    logic       do_emit;
    logic [6:0] e_ch;
    logic       fend;
    logic       pair_end;
    logic       final_c;
    logic [7:0] pair;

    assign out_ready = !i_out_full;
    assign field8    = 8'(r_field);
    assign type_sel  = (!r_comma_pend && i_nib_valid && (i_nib.start || r_type_pending))
                       ? i_nib.nib[1:0] : r_type;
    assign eff       = ({2'b00, r_count[type_sel]} > MAXF) ? MAXF
                       : {2'b00, r_count[type_sel]};
    assign quartet   = (field8 < 8'd32) && r_mask[r_type][field8[4:0]];
    assign final_c   = fend && ((field8 + 8'd1) >= eff);

    always_comb begin
        n_active       = r_active;
        n_type_pending = r_type_pending;
        n_type         = r_type;
        n_field        = r_field;
        n_lh           = r_lh;
        n_hv           = r_hv;
        n_cc           = r_cc;
        n_comma_pend   = r_comma_pend;
        o_nib_pop      = 1'b0;
        o_item_push    = 1'b0;
        o_item         = '0;
        do_emit        = 1'b0;
        e_ch           = '0;
        fend           = 1'b0;
        pair_end       = 1'b0;
        pair           = {i_nib.nib, r_lh};
        if (r_comma_pend) begin
            if (out_ready) begin
                do_emit      = 1'b1;
                e_ch         = nlsd_pkg::ASCII_COMMA;
                fend         = 1'b1;
                n_comma_pend = 1'b0;
            end
        end else if (i_nib_valid && out_ready) begin
            o_nib_pop = 1'b1;
            if (i_nib.start) begin
                n_active       = 1'b1;
                n_type_pending = 1'b1;
                n_field        = '0;
                n_cc           = '0;
                n_hv           = 1'b0;
                n_lh           = '0;
            end
            if (n_active) begin
                if (n_type_pending) begin
                    n_type_pending = 1'b0;
                    n_field        = '0;
                    n_cc           = '0;
                    n_hv           = 1'b0;
                    if (i_nib.nib > nlsd_pkg::NIB_MAX_TYPE) begin
                        n_type      = 2'd0;
                        n_active    = 1'b0;
                        o_item_push = 1'b1;
                        o_item      = '{out_char: '0, sentence_type: 2'd0, last_char: 1'b1,
                                        status: nlsd_pkg::STATUS_UNKNOWN};
                    end else begin
                        n_type = i_nib.nib[1:0];
                        if (eff == 8'd0) begin
                            n_active    = 1'b0;
                            o_item_push = 1'b1;
                            o_item      = '{out_char: '0, sentence_type: i_nib.nib[1:0],
                                            last_char: 1'b1, status: nlsd_pkg::STATUS_OK};
                        end
                    end
                end else if (quartet) begin
                    do_emit = 1'b1;
                    if (i_nib.nib == nlsd_pkg::NIB_END) begin
                        e_ch = nlsd_pkg::ASCII_COMMA;
                        fend = 1'b1;
                    end else if (i_nib.nib < nlsd_pkg::NIB_DIGITS) begin
                        e_ch = {3'b000, i_nib.nib} + nlsd_pkg::ASCII_ZERO;
                    end else begin
                        e_ch = {3'b000, i_nib.nib} + nlsd_pkg::ASCII_LOW;
                    end
                end else if (!r_hv) begin
                    n_lh = i_nib.nib;
                    n_hv = 1'b1;
                end else begin
                    n_hv = 1'b0;
                    if (pair[6:0] != nlsd_pkg::CHAR_SKIP) begin
                        do_emit  = 1'b1;
                        e_ch     = pair[6:0];
                        pair_end = pair[7];
                    end else if (pair[7]) begin
                        do_emit = 1'b1;
                        e_ch    = nlsd_pkg::ASCII_COMMA;
                        fend    = 1'b1;
                    end
                end
            end
        end
        if (do_emit) begin
            o_item_push = 1'b1;
            if (r_cc == CC_LAST) begin
                n_active = 1'b0;
                o_item   = '{out_char: '0, sentence_type: r_type, last_char: 1'b1,
                             status: nlsd_pkg::STATUS_OVERFLOW};
            end else begin
                n_cc   = r_cc + 1'b1;
                o_item = '{out_char: e_ch, sentence_type: r_type, last_char: final_c,
                           status: nlsd_pkg::STATUS_OK};
                if (final_c) begin
                    n_active = 1'b0;
                end
            end
            if (fend && n_active) begin
                n_field = r_field + 1'b1;
                n_hv    = 1'b0;
            end
            if (pair_end && n_active) begin
                n_comma_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_type_pending <= 1'b0;
            r_type         <= 2'd0;
            r_field        <= '0;
            r_lh           <= '0;
            r_hv           <= 1'b0;
            r_cc           <= '0;
            r_comma_pend   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_mask[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_active       <= n_active;
            r_type_pending <= n_type_pending;
            r_type         <= n_type;
            r_field        <= n_field;
            r_lh           <= n_lh;
            r_hv           <= n_hv;
            r_cc           <= n_cc;
            r_comma_pend   <= n_comma_pend;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nlsd_pkg::REG_MASK_RMC:  r_mask[0]  <= i_cfg_data;
                    nlsd_pkg::REG_MASK_GGA:  r_mask[1]  <= i_cfg_data;
                    nlsd_pkg::REG_MASK_GSA:  r_mask[2]  <= i_cfg_data;
                    nlsd_pkg::REG_MASK_VTG:  r_mask[3]  <= i_cfg_data;
                    nlsd_pkg::REG_COUNT_RMC: r_count[0] <= i_cfg_data[nlsd_pkg::COUNT_W-1:0];
                    nlsd_pkg::REG_COUNT_GGA: r_count[1] <= i_cfg_data[nlsd_pkg::COUNT_W-1:0];
                    nlsd_pkg::REG_COUNT_GSA: r_count[2] <= i_cfg_data[nlsd_pkg::COUNT_W-1:0];
                    nlsd_pkg::REG_COUNT_VTG: r_count[3] <= i_cfg_data[nlsd_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### design/nlsd_outq.sv
// result queue: four-entry register ring between the back end and the result ports
// depends on nlsd_pkg
module nlsd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nlsd_pkg::t_item i_item,
    output logic            o_full,
    output logic            empty,
    input  logic            pop,
    output nlsd_pkg::t_item o_item
);

    nlsd_pkg::t_item r_data [4];
    logic [1:0]      r_wr_ptr;
    logic [1:0]      r_rd_ptr;
    logic [2:0]      r_count;
    logic [2:0]      n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == 3'd4);
    assign empty   = (r_count == 3'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;
    assign o_item  = r_data[r_rd_ptr];

    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 3'd1;
            2'b01:   n_count = r_count - 3'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_item;
        end
    end

endmodule

### design/nibble_log_sentence_decoder_top.sv
// top level of the nibble log sentence decoder: front byte queue, back end, result queue
// depends on nlsd_pkg, nlsd_front, nlsd_exec, nlsd_outq
//
// channel   handshake                 payload
// input     push / full               i_rec_byte, i_rec_start
// result    empty / pop               o_out_char, o_sentence_type, o_last_char, o_status
// config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// the back end takes one nibble per cycle while one is waiting, the result queue has room
// and no comma is pending; a byte that closes a byte-coded field with a character adds a
// separate comma step. results are registered in a four-entry queue before the ports.
// a stalled pop fills the result queue, then the back end stops, then the two-byte front
// queue raises full. reset is synchronous and clears control and config state to zero.
module nibble_log_sentence_decoder_top #(
    parameter int SENTENCE_CAP = 256,
    parameter int MAX_FIELDS   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_rec_byte,
    input  logic                             i_rec_start,
    output logic                             empty,
    input  logic                             pop,
    output logic [6:0]                       o_out_char,
    output logic [1:0]                       o_sentence_type,
    output logic                             o_last_char,
    output logic [1:0]                       o_status,
    input  logic                             i_cfg_we,
    input  logic [nlsd_pkg::REG_INDEX_W-1:0] i_cfg_index,
    input  logic [nlsd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic              nib_valid;
    nlsd_pkg::t_nib_op nib;
    logic              nib_pop;
    logic              outq_full;
    logic              item_push;
    nlsd_pkg::t_item   item;
    nlsd_pkg::t_item   head;

    nlsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_rec_byte  (i_rec_byte),
        .i_rec_start (i_rec_start),
        .o_nib_valid (nib_valid),
        .o_nib       (nib),
        .i_nib_pop   (nib_pop)
    );

    nlsd_exec #(
        .SENTENCE_CAP (SENTENCE_CAP),
        .MAX_FIELDS   (MAX_FIELDS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_nib_valid (nib_valid),
        .i_nib       (nib),
        .o_nib_pop   (nib_pop),
        .i_out_full  (outq_full),
        .o_item_push (item_push),
        .o_item      (item)
    );

    nlsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_item  (item),
        .o_full  (outq_full),
        .empty   (empty),
        .pop     (pop),
        .o_item  (head)
    );

    assign o_out_char      = head.out_char;
    assign o_sentence_type = head.sentence_type;
    assign o_last_char     = head.last_char;
    assign o_status        = head.status;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_push |-> !outq_full)
        else $error("result pushed into a full queue");

    a_failure_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != nlsd_pkg::STATUS_OK) |-> (o_last_char && o_out_char == 7'd0))
        else $error("failure result not marked as last");

    a_unknown_type_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == nlsd_pkg::STATUS_UNKNOWN) |-> (o_sentence_type == 2'd0))
        else $error("unknown type result carries a type");

    a_pop_only_when_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nib_pop |-> nib_valid)
        else $error("nibble taken from an empty front queue");

endmodule

### dv/nlsd_checker.sv
// transaction checker of the nibble log sentence decoder: predicts result items from accepted bytes
// and register writes, and compares them in order with the popped results
// depends on nlsd_pkg
module nlsd_checker #(
    parameter int SENTENCE_CAP = 256,
    parameter int MAX_FIELDS   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_full,
    input  logic [7:0]                       i_rec_byte,
    input  logic                             i_rec_start,
    input  logic                             i_empty,
    input  logic                             i_pop,
    input  logic [6:0]                       i_out_char,
    input  logic [1:0]                       i_sentence_type,
    input  logic                             i_last_char,
    input  logic [1:0]                       i_status,
    input  logic                             i_cfg_we,
    input  logic [nlsd_pkg::REG_INDEX_W-1:0] i_cfg_index,
    input  logic [nlsd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import nlsd_pkg::*;

    logic [31:0]                    quartet_mask [4];
    logic [COUNT_W-1:0]             field_count [4];
    logic                           active;
    logic                           type_pending;
    logic [1:0]                     cur_type;
    logic [5:0]                     field_index;
    logic [3:0]                     low_hold;
    logic                           hold_valid;
    logic [$clog2(SENTENCE_CAP):0]  char_count;
    t_item                          expected_chars [$];
    int                             mismatches;

    function automatic int fields_in_model();
        int c;
        c = int'(field_count[cur_type]);
        return (c > MAX_FIELDS) ? MAX_FIELDS : c;
    endfunction

    function automatic void queue_char(logic [6:0] ch, logic last, logic [1:0] st);
        t_item it;
        it.out_char      = ch;
        it.sentence_type = cur_type;
        it.last_char     = last;
        it.status        = st;
        expected_chars.push_back(it);
    endfunction

    function automatic void predict_char(logic [6:0] ch, logic fin);
        if (int'(char_count) >= SENTENCE_CAP - 1) begin
            queue_char(7'd0, 1'b1, STATUS_OVERFLOW);
            active = 1'b0;
        end else begin
            queue_char(ch, fin, STATUS_OK);
            char_count = char_count + 1'b1;
            if (fin) begin
                active = 1'b0;
            end
        end
    endfunction

    function automatic void predict_comma();
        predict_char(ASCII_COMMA, (int'(field_index) + 1) >= fields_in_model());
        if (active) begin
            field_index = field_index + 1'b1;
            hold_valid  = 1'b0;
        end
    endfunction

    function automatic void predict_nibble(logic [3:0] n);
        logic       quartet;
        logic [7:0] pair;
        if (active && type_pending) begin
            type_pending = 1'b0;
            field_index  = '0;
            char_count   = '0;
            hold_valid   = 1'b0;
            if (n > NIB_MAX_TYPE) begin
                cur_type = 2'd0;
                queue_char(7'd0, 1'b1, STATUS_UNKNOWN);
                active = 1'b0;
            end else begin
                cur_type = n[1:0];
                if (fields_in_model() == 0) begin
                    queue_char(7'd0, 1'b1, STATUS_OK);
                    active = 1'b0;
                end
            end
        end else if (active) begin
            quartet = (field_index < 6'd32) && quartet_mask[cur_type][field_index[4:0]];
            if (quartet) begin
                if (n == NIB_END) begin
                    predict_comma();
                end else if (n < NIB_DIGITS) begin
                    predict_char(ASCII_ZERO + {3'b000, n}, 1'b0);
                end else begin
                    predict_char(ASCII_LOW + {3'b000, n}, 1'b0);
                end
            end else if (!hold_valid) begin
                low_hold   = n;
                hold_valid = 1'b1;
            end else begin
                pair       = {n, low_hold};
                hold_valid = 1'b0;
                if (pair[6:0] != CHAR_SKIP) begin
                    predict_char(pair[6:0], 1'b0);
                end
                if (active && pair[7]) begin
                    predict_comma();
                end
            end
        end
    endfunction

    function automatic void predict_log_byte(logic [7:0] b, logic s);
        if (s) begin
            active       = 1'b1;
            type_pending = 1'b1;
            field_index  = '0;
            char_count   = '0;
            hold_valid   = 1'b0;
            low_hold     = '0;
        end
        predict_nibble(b[3:0]);
        predict_nibble(b[7:4]);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_item want;
        t_item got;
        if (!i_rst_n) begin
            for (int t = 0; t < 4; t++) begin
                quartet_mask[t] = '0;
                field_count[t]  = '0;
            end
            active       = 1'b0;
            type_pending = 1'b0;
            cur_type     = '0;
            field_index  = '0;
            low_hold     = '0;
            hold_valid   = 1'b0;
            char_count   = '0;
            expected_chars.delete();
            mismatches   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MASK_RMC:  quartet_mask[0] = i_cfg_data;
                    REG_MASK_GGA:  quartet_mask[1] = i_cfg_data;
                    REG_MASK_GSA:  quartet_mask[2] = i_cfg_data;
                    REG_MASK_VTG:  quartet_mask[3] = i_cfg_data;
                    REG_COUNT_RMC: field_count[0]  = i_cfg_data[COUNT_W-1:0];
                    REG_COUNT_GGA: field_count[1]  = i_cfg_data[COUNT_W-1:0];
                    REG_COUNT_GSA: field_count[2]  = i_cfg_data[COUNT_W-1:0];
                    REG_COUNT_VTG: field_count[3]  = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                predict_log_byte(i_rec_byte, i_rec_start);
            end
            if (i_pop && !i_empty) begin
                got.out_char      = i_out_char;
                got.sentence_type = i_sentence_type;
                got.last_char     = i_last_char;
                got.status        = i_status;
                if (expected_chars.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected transaction: char %02h type %0d last %0d status %0d",
                                 got.out_char, got.sentence_type, got.last_char, got.status);
                    end
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want !== got) begin
                        if (mismatches < 10) begin
                            $write("mismatch: expected char %02h type %0d last %0d status %0d, ",
                                   want.out_char, want.sentence_type, want.last_char,
                                   want.status);
                            $display("got char %02h type %0d last %0d status %0d",
                                     got.out_char, got.sentence_type, got.last_char,
                                     got.status);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_chars.size();
        o_fail_count <= mismatches;
    end

endmodule

### dv/tb_nibble_log_sentence_decoder_top.sv
// testbench top of the nibble log sentence decoder: clock, reset, register setup, byte stimulus,
// random pop stalls, watchdog and verdict
// depends on nlsd_pkg, nibble_log_sentence_decoder_top and nlsd_checker
module tb_nibble_log_sentence_decoder_top;
    import nlsd_pkg::*;

    localparam int MAX_FIELDS     = 32;
    localparam int TARGET_BYTES   = 310;
    localparam int PHASE_BYTES    = 45;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             i_rec_byte;
    logic                   i_rec_start;
    logic                   empty;
    logic                   pop;
    logic [6:0]             o_out_char;
    logic [1:0]             o_sentence_type;
    logic                   o_last_char;
    logic [1:0]             o_status;
    logic                   i_cfg_we;
    logic [REG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int           fail_count;
    int           pending;
    int           stall_cycles = 0;
    int           bytes_sent = 0;
    bit           steady = 1'b0;
    logic [31:0]  mask_copy [4];
    logic [5:0]   count_copy [4];

    nibble_log_sentence_decoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_rec_byte      (i_rec_byte),
        .i_rec_start     (i_rec_start),
        .empty           (empty),
        .pop             (pop),
        .o_out_char      (o_out_char),
        .o_sentence_type (o_sentence_type),
        .o_last_char     (o_last_char),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    nlsd_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_rec_byte      (i_rec_byte),
        .i_rec_start     (i_rec_start),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out_char      (o_out_char),
        .i_sentence_type (o_sentence_type),
        .i_last_char     (o_last_char),
        .i_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        while (!steady && $urandom_range(0, 99) < 36) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_rec_byte  <= b;
        i_rec_start <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // drops push, then waits at falling clock edges until no result is pending
    task automatic wait_results();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_models(input logic [31:0] m0, input logic [31:0] m1,
                              input logic [31:0] m2, input logic [31:0] m3,
                              input logic [5:0] c0, input logic [5:0] c1,
                              input logic [5:0] c2, input logic [5:0] c3);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [REG_INDEX_W-1:0] regs [8];
        vals = '{m0, m1, m2, m3, {26'd0, c0}, {26'd0, c1}, {26'd0, c2}, {26'd0, c3}};
        regs = '{REG_MASK_RMC, REG_MASK_GGA, REG_MASK_GSA, REG_MASK_VTG,
                 REG_COUNT_RMC, REG_COUNT_GGA, REG_COUNT_GSA, REG_COUNT_VTG};
        mask_copy  = '{m0, m1, m2, m3};
        count_copy = '{c0, c1, c2, c3};
        for (int r = 0; r < 8; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 32'h5555_5555 ^ {32{1'($urandom_range(0, 1))}};
        endcase
    endfunction

    function automatic logic [5:0] pick_count();
        if ($urandom_range(0, 9) == 0) begin
            return 6'($urandom_range(7, 63));
        end
        return 6'($urandom_range(0, 6));
    endfunction

    // well-formed record per the current field models, optionally cut short, plus optional trailing noise
    task automatic send_record(input logic [3:0] typ, input bit broken);
        logic [3:0] nq [$];
        logic [7:0] b;
        int         fields;
        int         cut;
        nq.push_back(typ);
        if (typ <= NIB_MAX_TYPE) begin
            fields = int'(count_copy[typ[1:0]]);
            if (fields > MAX_FIELDS) begin
                fields = MAX_FIELDS;
            end
            for (int f = 0; f < fields; f++) begin
                if (mask_copy[typ[1:0]][f]) begin
                    repeat ($urandom_range(0, 3)) nq.push_back(4'($urandom_range(0, 14)));
                    nq.push_back(NIB_END);
                end else begin
                    repeat ($urandom_range(0, 2)) begin
                        b = ($urandom_range(0, 7) == 0) ? 8'h7F : 8'($urandom_range(0, 127));
                        nq.push_back(b[3:0]);
                        nq.push_back(b[7:4]);
                    end
                    b = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(128, 255));
                    nq.push_back(b[3:0]);
                    nq.push_back(b[7:4]);
                end
            end
        end
        if (broken) begin
            cut = $urandom_range(1, nq.size());
            while (nq.size() > cut) void'(nq.pop_back());
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) nq.push_back(4'($urandom_range(0, 15)));
        end
        if (nq.size() % 2 != 0) begin
            nq.push_back(4'($urandom_range(0, 15)));
        end
        for (int i = 0; i < nq.size(); i += 2) begin
            if (i != 0 && $urandom_range(0, 99) == 0) begin
                wait_results();
            end
            send_byte({nq[i+1], nq[i]}, i == 0);
        end
    endtask

    initial begin
        int   phase_start;
        int   pick;
        logic [3:0] typ;
        push        = 1'b0;
        i_rec_byte  = '0;
        i_rec_start = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: quartet and byte coding, skip pairs, unknown type, empty model, restarts
        set_models(32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h5555_5555,
                   6'd3, 6'd2, 6'd0, 6'd63);
        send_byte(8'h00, 1'b1);
        send_byte(8'hF9, 1'b0);
        send_byte(8'hEA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h37, 1'b0);
        send_byte(8'hF4, 1'b1);
        send_byte(8'h0F, 1'b1);
        send_byte(8'h22, 1'b1);
        send_byte(8'h51, 1'b1);
        send_byte(8'hC4, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_results();
        send_byte(8'h00, 1'b0);
        send_byte(8'h73, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hA3, 1'b1);
        send_byte(8'h00, 1'b1);
        settle();

        // all-quartet models, all but GSA at full field count, one record run up to capacity
        steady = 1'b1;
        set_models(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   6'd32, 6'd63, 6'd1, 6'd32);
        send_byte({4'($urandom_range(0, 14)), 4'h0}, 1'b1);
        repeat (129) send_byte({4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))}, 1'b0);
        send_record(4'h1, 1'b0);
        send_record(4'h2, 1'b0);
        steady = 1'b0;

        while (bytes_sent < TARGET_BYTES) begin
            settle();
            set_models(pick_mask(), pick_mask(), pick_mask(), pick_mask(),
                       pick_count(), pick_count(), pick_count(), pick_count());
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < TARGET_BYTES) begin
                pick = $urandom_range(0, 99);
                typ  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15))
                                                   : 4'($urandom_range(0, 3));
                if (pick < 10) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
                    end
                end else begin
                    send_record(typ, pick < 25);
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### nibble_log_sentence_decoder_top.f
design/nlsd_pkg.sv
design/nlsd_front.sv
design/nlsd_exec.sv
design/nlsd_outq.sv
design/nibble_log_sentence_decoder_top.sv
dv/nlsd_checker.sv
dv/tb_nibble_log_sentence_decoder_top.sv
